// ----- sv/lds_pkg.sv -----
// ----------------------------------------------------------------------------
// lds_pkg: shared types and constants of the Lorentz dielectric sum
// Item and result structs, configuration and divider structs, the state
// enum of the sequencer and the fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

  localparam int MAX_OSC_DEF = 8;

  // round(1239.84193 * 2^32): photon energy numerator for Q16.16 results.
  localparam logic [63:0] ENERGY_NUM = 64'd5325080541560;
  // Largest magnitude one oscillator term may contribute.
  localparam logic [40:0] TERM_LIMIT = 41'h100_0000_0000;
  localparam int ACC_W = 48;

  // Register indexes, taken from paddr[2].
  localparam logic REG_EPS_INF = 1'b0;
  localparam logic REG_ACTIVE  = 1'b1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } lds_op_e;

  typedef struct packed {
    logic              func;
    logic [2:0]        osc_index;
    logic signed [31:0] osc_damping;
    logic signed [31:0] osc_center;
    logic signed [31:0] osc_strength;
    logic [31:0]       wavelength;
  } lds_in_t;

  typedef struct packed {
    logic signed [31:0] eps_real;
    logic signed [31:0] eps_imag;
    logic              saturated;
  } lds_out_t;

  typedef struct packed {
    lds_op_e op;
    lds_in_t item;
  } lds_entry_t;

  typedef struct packed {
    logic signed [31:0] eps_infinity;
    logic [3:0]        active_oscillators;
  } lds_cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] na;
    logic [63:0] nb;
    logic [63:0] dv;
    logic [6:0]  steps;
  } lds_div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [40:0] qa;
    logic [40:0] qb;
    logic        ovfa;
    logic        ovfb;
  } lds_div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EDIV,
    ST_EWAIT,
    ST_WSQ,
    ST_WSQ2,
    ST_NEXT,
    ST_C2,
    ST_S2,
    ST_BM,
    ST_CHK,
    ST_TST,
    ST_NORM,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_N1,
    ST_N2,
    ST_DWAIT,
    ST_FIN
  } lds_state_e;

endpackage

`default_nettype wire

// ----- sv/lorentz_dielectric_sum.sv -----
// ----------------------------------------------------------------------------
// lorentz_dielectric_sum: Lorentz oscillator dielectric function evaluator
// Sums eps_infinity and up to MaxOsc Lorentz terms at a given wavelength.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low; busy rises only
// when the two-entry intake queue is full. A load item writes a table entry
// when the back end pops it. An evaluate item with a zero wavelength gives a
// saturated zero result; any other first forms the photon energy and its
// square. Then each active oscillator goes through table reads and
// multiplies, normalising shifts and a division; a term that is skipped
// needs no division. The two-lane restoring divider gives one quotient bit
// per cycle.
// Each result is shown for exactly one cycle with done_o high; the
// receiver cannot stall it. Results saturate to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module lorentz_dielectric_sum #(
  parameter int MaxOsc = lds_pkg::MAX_OSC_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire lds_pkg::lds_in_t item_i,
  output logic                  done_o,
  output lds_pkg::lds_out_t     result_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import lds_pkg::*;

  lds_cfg_t     cfg;
  logic         q_valid, q_pop;
  lds_entry_t   q_entry;
  lds_div_req_t div_req;
  lds_div_rsp_t div_rsp;

  // Front end: registers, classification and the intake queue.
  lds_front #(.MaxOsc(MaxOsc)) u_front (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg), .q_valid_o(q_valid), .q_entry_o(q_entry), .q_pop_i(q_pop)
  );

  // Back end: table, sequencer and the shared multiplier.
  lds_back #(.MaxOsc(MaxOsc)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .q_valid_i(q_valid), .q_entry_i(q_entry),
    .q_pop_o(q_pop), .div_req_o(div_req), .div_rsp_i(div_rsp),
    .done_o, .result_o
  );

  // The one divider serves both the energy and every term.
  lds_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp)
  );

endmodule

`default_nettype wire

// ----- sv/lds_front.sv -----
// ----------------------------------------------------------------------------
// lds_front: configuration registers and item intake
// Holds the APB registers, classifies accepted items and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_front #(
  parameter int MaxOsc = lds_pkg::MAX_OSC_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire lds_pkg::lds_in_t item_i,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output lds_pkg::lds_cfg_t     cfg_o,
  output logic                  q_valid_o,
  output lds_pkg::lds_entry_t   q_entry_o,
  input  wire logic             q_pop_i
);
  import lds_pkg::*;

  lds_cfg_t   cfg_q, cfg_d;
  lds_entry_t q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, keep;
  lds_entry_t entry;

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_EPS_INF: cfg_d.eps_infinity = pwdata;
        REG_ACTIVE:  cfg_d.active_oscillators = pwdata[3:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_EPS_INF: prdata = cfg_q.eps_infinity;
      REG_ACTIVE:  prdata = {28'd0, cfg_q.active_oscillators};
      default:     prdata = '0;
    endcase
  end

  // Loads aimed beyond the table are dropped here.
  always_comb begin
    entry.item = item_i;
    entry.op   = item_i.func ? OP_EVAL : OP_LOAD;
    keep       = (entry.op == OP_EVAL) || (32'(item_i.osc_index) < MaxOsc);
  end

  assign busy      = (cnt_q == 2'd2);
  assign push      = start && !busy && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_entry_o = q_mem[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= '{eps_infinity: 32'sh0001_0000, active_oscillators: 4'd0};
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lds_div.sv -----
// ----------------------------------------------------------------------------
// lds_div: two-lane restoring divider
// Divides two dividends by one divisor, one quotient bit a cycle, and
// flags quotients that pass the term limit.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lds_pkg::lds_div_req_t req_i,
  output lds_pkg::lds_div_rsp_t      rsp_o
);
  import lds_pkg::*;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] na_q, nb_q, dv_q, ra_q, rb_q;
  logic [41:0] qa_q, qb_q;
  logic        ovfa_q, ovfb_q;
  logic [63:0] ra_sh, rb_sh;
  logic        gea, geb;
  logic [41:0] qa_n, qb_n;

  assign ra_sh = {ra_q[62:0], na_q[63]};
  assign rb_sh = {rb_q[62:0], nb_q[63]};
  assign gea   = (ra_sh >= dv_q);
  assign geb   = (rb_sh >= dv_q);
  assign qa_n  = {qa_q[40:0], gea};
  assign qb_n  = {qb_q[40:0], geb};

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.ovfa = ovfa_q;
  assign rsp_o.ovfb = ovfb_q;
  assign rsp_o.qa   = ovfa_q ? TERM_LIMIT : qa_q[40:0];
  assign rsp_o.qb   = ovfb_q ? TERM_LIMIT : qb_q[40:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      na_q   <= req_i.na;
      nb_q   <= req_i.nb;
      dv_q   <= req_i.dv;
      ra_q   <= '0;
      rb_q   <= '0;
      qa_q   <= '0;
      qb_q   <= '0;
      ovfa_q <= 1'b0;
      ovfb_q <= 1'b0;
    end else if (busy_q) begin
      na_q   <= {na_q[62:0], 1'b0};
      nb_q   <= {nb_q[62:0], 1'b0};
      ra_q   <= gea ? ra_sh - dv_q : ra_sh;
      rb_q   <= geb ? rb_sh - dv_q : rb_sh;
      qa_q   <= qa_n;
      qb_q   <= qb_n;
      ovfa_q <= ovfa_q || (qa_n > 42'(TERM_LIMIT));
      ovfb_q <= ovfb_q || (qb_n > 42'(TERM_LIMIT));
    end
  end

endmodule

`default_nettype wire

// ----- sv/lds_back.sv -----
// ----------------------------------------------------------------------------
// lds_back: oscillator table and evaluation sequencer
// Writes table entries, forms the photon energy and sums the oscillator
// terms through one shared multiplier and the two-lane divider.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_back #(
  parameter int MaxOsc = lds_pkg::MAX_OSC_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lds_pkg::lds_cfg_t    cfg_i,
  input  wire logic                 q_valid_i,
  input  wire lds_pkg::lds_entry_t  q_entry_i,
  output logic                      q_pop_o,
  output lds_pkg::lds_div_req_t     div_req_o,
  input  wire lds_pkg::lds_div_rsp_t div_rsp_i,
  output logic                      done_o,
  output lds_pkg::lds_out_t         result_o
);
  import lds_pkg::*;

  localparam int AW = (MaxOsc > 1) ? $clog2(MaxOsc) : 1;

  lds_state_e state_q, state_d;
  logic [95:0] tbl_mem [MaxOsc];
  logic [95:0] rd_q;
  logic [3:0]  n_q, i_q;
  logic [31:0] len_q, wq_q;
  logic [63:0] wsq_q, mul_q, c2_q, s2_q, am_q, bm_q, d_q, na_q;
  logic        aneg_q, gneg_q, sat_q, done_q;
  logic [5:0]  k_q, m_q;
  logic signed [ACC_W-1:0] re_q, im_q;
  lds_out_t    res_q;
  logic [31:0] mul_a, mul_b;
  logic [31:0] g_mag, c_mag, s_mag;
  logic        abig, sbig;
  logic [3:0]  n_sel;
  logic [ACC_W-1:0] ta, tb;

  assign g_mag = rd_q[95] ? (~rd_q[95:64] + 32'd1) : rd_q[95:64];
  assign c_mag = rd_q[63] ? (~rd_q[63:32] + 32'd1) : rd_q[63:32];
  assign s_mag = rd_q[31] ? (~rd_q[31:0] + 32'd1) : rd_q[31:0];
  assign abig  = (am_q[63:31] != '0) || (bm_q[63:31] != '0);
  assign sbig  = (s2_q[63:32] != '0);
  assign n_sel = (32'(cfg_i.active_oscillators) > MaxOsc) ? 4'(MaxOsc)
                                                          : cfg_i.active_oscillators;
  assign ta    = ACC_W'(div_rsp_i.qa);
  assign tb    = ACC_W'(div_rsp_i.qb);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i && q_entry_i.op == OP_EVAL && q_entry_i.item.wavelength != '0) begin
          state_d = ST_EDIV;
        end
      end
      ST_EDIV:  state_d = ST_EWAIT;
      ST_EWAIT: if (div_rsp_i.done) state_d = ST_WSQ;
      ST_WSQ:   state_d = ST_WSQ2;
      ST_WSQ2:  state_d = ST_NEXT;
      ST_NEXT:  state_d = (i_q < n_q) ? ST_C2 : ST_FIN;
      ST_C2:    state_d = ST_S2;
      ST_S2:    state_d = ST_BM;
      ST_BM:    state_d = ST_CHK;
      ST_CHK:   state_d = ST_TST;
      ST_TST: begin
        if ((am_q == '0 && bm_q == '0) || s2_q == '0) begin
          state_d = ST_NEXT;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM:  if (!abig && !sbig) state_d = ST_D1;
      ST_D1:    state_d = ST_D2;
      ST_D2:    state_d = ST_D3;
      ST_D3:    state_d = ST_N1;
      ST_N1:    state_d = ST_N2;
      ST_N2:    state_d = ST_DWAIT;
      ST_DWAIT: if (div_rsp_i.done) state_d = ST_NEXT;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs: queue pop, multiplier operands, divider request.
  always_comb begin
    q_pop_o         = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    div_req_o.start = 1'b0;
    div_req_o.na    = na_q;
    div_req_o.nb    = mul_q;
    div_req_o.dv    = d_q;
    div_req_o.steps = 7'(7'd80 + 7'(m_q) - 7'(k_q));
    case (state_q)
      ST_IDLE: q_pop_o = q_valid_i;
      ST_EDIV: begin
        div_req_o.start = 1'b1;
        div_req_o.na    = ENERGY_NUM + 64'(len_q >> 1);
        div_req_o.nb    = '0;
        div_req_o.dv    = 64'(len_q);
        div_req_o.steps = 7'd64;
      end
      ST_WSQ: begin
        mul_a = wq_q;
        mul_b = wq_q;
      end
      ST_C2: begin
        mul_a = c_mag;
        mul_b = c_mag;
      end
      ST_S2: begin
        mul_a = s_mag;
        mul_b = s_mag;
      end
      ST_BM: begin
        mul_a = g_mag;
        mul_b = wq_q;
      end
      ST_D1: begin
        mul_a = am_q[31:0];
        mul_b = am_q[31:0];
      end
      ST_D2: begin
        mul_a = bm_q[31:0];
        mul_b = bm_q[31:0];
      end
      ST_D3: begin
        mul_a = s2_q[31:0];
        mul_b = am_q[31:0];
      end
      ST_N1: begin
        mul_a = s2_q[31:0];
        mul_b = bm_q[31:0];
      end
      ST_N2:   div_req_o.start = 1'b1;
      default: q_pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FIN) ||
                 (state_q == ST_IDLE && q_valid_i && q_entry_i.op == OP_EVAL &&
                  q_entry_i.item.wavelength == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q  <= tbl_mem[AW'(i_q)];
    mul_q <= 64'(mul_a) * 64'(mul_b);
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          len_q <= q_entry_i.item.wavelength;
          n_q   <= n_sel;
          sat_q <= 1'b0;
          if (q_entry_i.op == OP_LOAD) begin
            tbl_mem[AW'(q_entry_i.item.osc_index)] <= {q_entry_i.item.osc_damping,
                                                       q_entry_i.item.osc_center,
                                                       q_entry_i.item.osc_strength};
          end else if (q_entry_i.item.wavelength == '0) begin
            res_q <= '{eps_real: '0, eps_imag: '0, saturated: 1'b1};
          end
        end
      end
      ST_EWAIT: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.ovfa || div_rsp_i.qa > 41'h0_7FFF_FFFF) begin
            wq_q  <= 32'h7FFF_FFFF;
            sat_q <= 1'b1;
          end else begin
            wq_q <= div_rsp_i.qa[31:0];
          end
          re_q <= ACC_W'(cfg_i.eps_infinity);
          im_q <= '0;
        end
      end
      ST_WSQ2: begin
        wsq_q <= mul_q;
        i_q   <= 4'd0;
      end
      ST_S2:  c2_q <= mul_q;
      ST_BM:  s2_q <= mul_q;
      ST_CHK: begin
        bm_q   <= mul_q;
        aneg_q <= (c2_q < wsq_q);
        am_q   <= (c2_q < wsq_q) ? wsq_q - c2_q : c2_q - wsq_q;
        gneg_q <= rd_q[95];
      end
      ST_TST: begin
        k_q <= 6'd0;
        m_q <= 6'd0;
        if (am_q == '0 && bm_q == '0) begin
          sat_q <= 1'b1;
          i_q   <= i_q + 4'd1;
        end else if (s2_q == '0) begin
          i_q <= i_q + 4'd1;
        end
      end
      ST_NORM: begin
        if (abig) begin
          am_q <= am_q >> 1;
          bm_q <= bm_q >> 1;
          k_q  <= k_q + 6'd1;
        end
        if (sbig) begin
          s2_q <= s2_q >> 1;
          m_q  <= m_q + 6'd1;
        end
      end
      ST_D2: d_q  <= mul_q;
      ST_D3: d_q  <= d_q + mul_q;
      ST_N1: na_q <= mul_q;
      ST_DWAIT: begin
        if (div_rsp_i.done) begin
          re_q  <= aneg_q ? re_q - $signed(ta) : re_q + $signed(ta);
          im_q  <= gneg_q ? im_q - $signed(tb) : im_q + $signed(tb);
          sat_q <= sat_q || div_rsp_i.ovfa || div_rsp_i.ovfb;
          i_q   <= i_q + 4'd1;
        end
      end
      ST_FIN: begin
        res_q.eps_real  <= (re_q > 48'sh0000_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                           (re_q < -48'sh0000_8000_0000) ? 32'sh8000_0000 : re_q[31:0];
        res_q.eps_imag  <= (im_q > 48'sh0000_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                           (im_q < -48'sh0000_8000_0000) ? 32'sh8000_0000 : im_q[31:0];
        res_q.saturated <= sat_q || (re_q > 48'sh0000_7FFF_FFFF) ||
                           (re_q < -48'sh0000_8000_0000) ||
                           (im_q > 48'sh0000_7FFF_FFFF) || (im_q < -48'sh0000_8000_0000);
      end
      default: ;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> !div_rsp_i.busy)
    else $error("divider started while busy");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_D1) |-> (k_q <= 6'd33 && m_q <= 6'd32))
    else $error("normalising shift out of range");

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> done_q)
    else $error("finished evaluation gave no result");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE && q_valid_i))
    else $error("queue popped outside idle");

endmodule

`default_nettype wire
